FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  `ASSERT_ALWAYS(name, clk, rst_n, (ante) |-> (cons))
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  `ASSERT_ALWAYS(name, clk, rst_n, (ante) |=> (cons))
`endif

FILE: hw/rtl/grbk_pkg.sv
// types and constants of the group-records-by-key unit
// no dependencies
`default_nettype none
package grbk_pkg;
  localparam int MaxRecords = 1024;
  localparam int IdxW = $clog2(MaxRecords);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 64;
  localparam int PointW = 24;
  localparam int SourceW = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_PULL_OUT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PointW-1:0]  point;
    logic [SourceW-1:0] source;
    logic [IdxW-1:0]    rec;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } tbl_req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/grbk_table.sv
// sorted record table, one write and one registered read per cycle
// depends on grbk_pkg
`default_nettype none
module grbk_table (
  input  wire logic              clk_i,
  input  wire grbk_pkg::tbl_req_t req_i,
  output grbk_pkg::entry_t       rd_o
);
  grbk_pkg::entry_t mem [grbk_pkg::MaxRecords];
  grbk_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_o = rd_q;
endmodule
`default_nettype wire

FILE: hw/rtl/group_records_by_key_unit.sv
// top level: stable insertion into a sorted table on push, grouped read on pull
// depends on grbk_pkg and grbk_table
//
// channel  | signals                       | handshake
// command  | op, key, point, source        | start_i high while busy_o low
// result   | element fields, overflow      | result_valid_o, one cycle, no stall
//
// clear, ignored op and dropped push finish in ST_IDLE; pull: read on accept,
// result in ST_PULL_OUT; push: ST_INS_CHK writes the new record at index 0 if
// no record is left below it, else reads the one below; ST_INS_CMP moves that
// record up if its key is larger and loops back, else writes the new record
// reset leaves the table empty; stored entries are undefined until written
`default_nettype none
module group_records_by_key_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [63:0] record_key_i,
  input  wire logic [23:0] point_index_i,
  input  wire logic [15:0] source_io_i,
  output logic             result_valid_o,
  output logic             has_element_o,
  output logic [9:0]       position_o,
  output logic [63:0]      group_key_o,
  output logic [23:0]      out_point_index_o,
  output logic [15:0]      out_source_io_o,
  output logic [9:0]       record_number_o,
  output logic [9:0]       entry_index_o,
  output logic             group_start_o,
  output logic             last_o,
  output logic             overflow_o
);
  localparam int IdxW = grbk_pkg::IdxW;
  localparam int CntW = grbk_pkg::CntW;

  grbk_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, rp_q, rp_d, j_q, j_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [grbk_pkg::KeyW-1:0] prev_q, prev_d;
  logic ovf_q, ovf_d, has_q, has_d;
  grbk_pkg::entry_t new_q, new_d, rd;
  grbk_pkg::tbl_req_t req;
  logic accept, start_grp;
  logic [CntW-1:0] j_m1;

  assign accept = start_i && !busy_o;
  assign j_m1 = j_q - CntW'(1);

  grbk_table u_table (
    .clk_i (clk_i),
    .req_i (req),
    .rd_o  (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grbk_pkg::ST_IDLE;
      cnt_q   <= '0;
      rp_q    <= '0;
      j_q     <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
      ovf_q   <= 1'b0;
      has_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rp_q    <= rp_d;
      j_q     <= j_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      ovf_q   <= ovf_d;
      has_q   <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

  assign start_grp = (rp_q == '0) || (rd.key != prev_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rp_d    = rp_q;
    j_d     = j_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    ovf_d   = ovf_q;
    has_d   = has_q;
    new_d   = new_q;
    req     = '0;
    busy_o  = (state_q != grbk_pkg::ST_IDLE);

    result_valid_o    = 1'b0;
    has_element_o     = 1'b0;
    position_o        = '0;
    group_key_o       = '0;
    out_point_index_o = '0;
    out_source_io_o   = '0;
    record_number_o   = '0;
    entry_index_o     = '0;
    group_start_o     = 1'b0;
    last_o            = 1'b0;
    overflow_o        = 1'b0;

    case (state_q)
      grbk_pkg::ST_IDLE: begin
        if (accept) begin
          case (grbk_pkg::op_e'(op_i))
            grbk_pkg::OP_CLEAR: begin
              cnt_d  = '0;
              rp_d   = '0;
              cur_d  = '0;
              prev_d = '0;
              ovf_d  = 1'b0;
            end
            grbk_pkg::OP_PUSH: begin
              rp_d   = '0;
              cur_d  = '0;
              prev_d = '0;
              if (cnt_q == CntW'(grbk_pkg::MaxRecords)) begin
                ovf_d = 1'b1;
              end else begin
                new_d.key    = record_key_i;
                new_d.point  = point_index_i;
                new_d.source = source_io_i;
                new_d.rec    = cnt_q[IdxW-1:0];
                j_d          = cnt_q;
                state_d      = grbk_pkg::ST_INS_CHK;
              end
            end
            grbk_pkg::OP_PULL: begin
              has_d     = (rp_q < cnt_q);
              req.re    = 1'b1;
              req.raddr = rp_q[IdxW-1:0];
              state_d   = grbk_pkg::ST_PULL_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      grbk_pkg::ST_INS_CHK: begin
        if (j_q == '0) begin
          req.we    = 1'b1;
          req.waddr = '0;
          req.wdata = new_q;
          cnt_d     = cnt_q + CntW'(1);
          state_d   = grbk_pkg::ST_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = j_m1[IdxW-1:0];
          state_d   = grbk_pkg::ST_INS_CMP;
        end
      end
      grbk_pkg::ST_INS_CMP: begin
        req.we    = 1'b1;
        req.waddr = j_q[IdxW-1:0];
        if (rd.key > new_q.key) begin
          req.wdata = rd;
          j_d       = j_m1;
          state_d   = grbk_pkg::ST_INS_CHK;
        end else begin
          req.wdata = new_q;
          cnt_d     = cnt_q + CntW'(1);
          state_d   = grbk_pkg::ST_IDLE;
        end
      end
      grbk_pkg::ST_PULL_OUT: begin
        result_valid_o = 1'b1;
        overflow_o     = ovf_q;
        state_d        = grbk_pkg::ST_IDLE;
        if (has_q) begin
          has_element_o     = 1'b1;
          position_o        = rp_q[IdxW-1:0];
          group_key_o       = rd.key;
          out_point_index_o = rd.point;
          out_source_io_o   = rd.source;
          record_number_o   = rd.rec;
          group_start_o     = start_grp;
          last_o            = (rp_q + CntW'(1) == cnt_q);
          if (rp_q == '0) begin
            cur_d = '0;
          end else if (start_grp) begin
            cur_d = cur_q + IdxW'(1);
          end
          entry_index_o = cur_d;
          prev_d        = rd.key;
          rp_d          = rp_q + CntW'(1);
        end
      end
      default: begin
        state_d = grbk_pkg::ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/grbk_checker.sv
// port-level checks of the group-records-by-key unit, bound to the top level
// depends on grbk_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module grbk_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic [1:0] op_i,
  input wire logic       result_valid_o,
  input wire logic       has_element_o,
  input wire logic       group_start_o,
  input wire logic       last_o
);
  logic pull_acc, other_acc;
  assign pull_acc  = start_i && !busy_o && (op_i == grbk_pkg::OP_PULL);
  assign other_acc = start_i && !busy_o && (op_i != grbk_pkg::OP_PULL);

  `ASSERT_NEXT(a_pull_word, clk_i, rst_ni, pull_acc, result_valid_o)
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, other_acc, !result_valid_o)
  `ASSERT_IMPLIES(a_busy_out, clk_i, rst_ni, result_valid_o, busy_o)
  `ASSERT_IMPLIES(a_empty_word, clk_i, rst_ni, result_valid_o && !has_element_o,
                  !group_start_o && !last_o)
  `ASSERT_NEXT(a_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
endmodule

bind group_records_by_key_unit grbk_checker u_grbk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .op_i           (op_i),
  .result_valid_o (result_valid_o),
  .has_element_o  (has_element_o),
  .group_start_o  (group_start_o),
  .last_o         (last_o)
);
`default_nettype wire
